// ----- rtl/pem_pkg.sv -----
// Shared widths and handshake structs for the pulse energy meter.
// Used by the bit-serial divider and by the meter core; no dependencies.
package pem_pkg;

    localparam int AVG_DEPTH = 5;
    localparam int CNT_W     = 32;
    localparam int PPU_W     = 16;
    localparam int MILLI_W   = CNT_W + 10;
    localparam int FILL_W    = $clog2(AVG_DEPTH + 1);
    localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W     = CNT_W + FILL_W;
    localparam int NUM_W     = (MILLI_W > SUM_W) ? MILLI_W : SUM_W;
    localparam int DEN_W     = PPU_W + CNT_W;
    localparam int STEP_W    = $clog2(NUM_W + 1);

    // Request to the divider: start pulse and number of quotient bits.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    // Divider status: busy while stepping, done for one cycle at the end.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ----- rtl/pem_serial_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
// Depends on pem_pkg for widths and the control and status structs.
module pem_serial_div import pem_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctl         i_ctl,
    input  logic [NUM_W-1:0] i_num,   // dividend, left-aligned to the step count
    input  logic [DEN_W-1:0] i_den,
    output t_div_sts         o_sts,
    output logic [NUM_W-1:0] o_quo
);

    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    trial;
    logic [DEN_W+1:0]  diff;
    logic              fits;
    logic [DEN_W-1:0]  n_rem;
    logic [NUM_W-1:0]  n_quo;

    // The next dividend bit enters the partial remainder from the top of the
    // quotient register, while the new quotient bit enters at the bottom.
    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        diff  = {1'b0, trial} - {2'b00, r_den};
        fits  = ~diff[DEN_W+1];
        n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_quo = {r_quo[NUM_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= i_ctl.steps;
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_quo  <= n_quo;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - STEP_W'(1);
                r_done <= (r_cnt == STEP_W'(1));
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule

// ----- rtl/pulse_energy_meter_core.sv -----
// Each request is carried through in turn by three passes of one bit-serial divider (32, 42
// and 35 quotient bits); a new request is taken only after the previous result has been
// loaded into the output register.
// Reset: synchronous, active low; clears the pulse counter, period, last pulse time and the
// average window, and loads 1000 pulses per unit and a 500 ms lockout.
module pulse_energy_meter_core import pem_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [15:0]  i_cfg_data,
    // Request stream.
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,   // [31:0] now_ms
    input  logic [1:0]   i_s_axis_tuser,   // [1:0] opcode
    // Result stream.
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [159:0] o_m_axis_tdata,   // [31:0] pulse_count, [63:32] period_ms,
                                           // [95:64] power_watts, [127:96] total_milli_units,
                                           // [159:128] average_watts
    output logic         o_m_axis_tuser    // [0] accepted
);

    // Register indexes of the configuration port.
    localparam logic CFG_PPU     = 1'b0;
    localparam logic CFG_LOCKOUT = 1'b1;

    // Request opcodes. The unused fourth code behaves as a plain read.
    localparam logic [1:0] OP_PULSE  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // Energy constant: 3.6e9 watt-milliseconds per kilowatt-hour.
    localparam logic [CNT_W-1:0] WATT_NUM = 32'd3600000000;

    // Each request walks the states in order. The divider is started once for the
    // power estimate, once for the energy total and once for the running average.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_WSTART,
        S_WWAIT,
        S_SAMPLE,
        S_TSTART,
        S_TWAIT,
        S_ASTART,
        S_AWAIT,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [PPU_W-1:0]   r_ppu;
    logic [15:0]        r_lockout;
    logic [1:0]         r_op;
    logic [CNT_W-1:0]   r_now;
    logic [CNT_W-1:0]   r_last;
    logic [CNT_W-1:0]   r_period;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_tgt;
    logic               r_zero;
    logic [DEN_W-1:0]   r_den;
    logic [CNT_W-1:0]   r_power;
    logic [CNT_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_avg;
    logic               r_acc;
    logic [CNT_W-1:0]   r_window [AVG_DEPTH];
    logic [SUM_W-1:0]   r_sum;
    logic [FILL_W-1:0]  r_fill;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_out_valid;
    logic [159:0]       r_out_data;
    logic               r_out_user;

    logic [CNT_W-1:0]   elapsed_ms;
    logic [PPU_W-1:0]   ppu_eff;
    logic [NUM_W-1:0]   milli_num;
    t_div_ctl           div_ctl;
    t_div_sts           div_sts;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [NUM_W-1:0]   div_quo;

    // Elapsed time wraps with the timestamp, so plain modular subtraction is right.
    assign elapsed_ms = r_now - r_last;

    // A zero pulses-per-unit setting is treated as one.
    assign ppu_eff = (r_ppu == '0) ? PPU_W'(1) : r_ppu;

    // count * 1000 as shifts: 1024 - 16 - 8.
    assign milli_num = (NUM_W'(r_count) << 10) - (NUM_W'(r_count) << 4)
                     - (NUM_W'(r_count) << 3);

    // Divider operands. Dividends are left-aligned so that the quotient ends up
    // in the low bits after the requested number of steps.
    always_comb begin
        div_ctl.start = 1'b0;
        div_ctl.steps = '0;
        div_num       = '0;
        div_den       = '0;
        case (r_state)
            S_WSTART: begin
                div_ctl.start = 1'b1;
                div_ctl.steps = STEP_W'(CNT_W);
                div_num       = NUM_W'(WATT_NUM) << (NUM_W - CNT_W);
                div_den       = r_den;
            end
            S_TSTART: begin
                div_ctl.start = 1'b1;
                div_ctl.steps = STEP_W'(NUM_W);
                div_num       = milli_num;
                div_den       = DEN_W'(ppu_eff);
            end
            S_ASTART: begin
                div_ctl.start = 1'b1;
                div_ctl.steps = STEP_W'(SUM_W);
                div_num       = NUM_W'(r_sum) << (NUM_W - SUM_W);
                div_den       = DEN_W'(r_fill);
            end
            default: begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    pem_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    // Configuration registers. Writes are to arrive only while the core is idle; the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppu     <= 16'd1000;
            r_lockout <= 16'd500;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PPU:     r_ppu     <= i_cfg_data;
                CFG_LOCKOUT: r_lockout <= i_cfg_data;
                default:     r_ppu     <= r_ppu;
            endcase
        end
    end

    // Sequencer, meter state and the output register. The output register lets a
    // new request in while the previous result still waits downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_period    <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_fill      <= '0;
            r_slot      <= '0;
            for (int k = 0; k < AVG_DEPTH; k++) begin
                r_window[k] <= '0;
            end
        end else begin
            // In the final state the output register is handled there alone.
            if (r_out_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op    <= i_s_axis_tuser;
                        r_now   <= i_s_axis_tdata;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    // Pick the period that the power estimate is based on. A pulse
                    // inside the lockout window leaves all pulse state untouched.
                    if (r_op == OP_PULSE) begin
                        if (elapsed_ms >= CNT_W'(r_lockout)) begin
                            r_acc    <= 1'b1;
                            r_count  <= r_count + CNT_W'(1);
                            r_period <= elapsed_ms;
                            r_last   <= r_now;
                            r_tgt    <= elapsed_ms;
                        end else begin
                            r_acc <= 1'b0;
                            r_tgt <= r_period;
                        end
                    end else begin
                        r_acc <= 1'b0;
                        if (r_period == '0) begin
                            r_tgt <= '0;
                        end else if (elapsed_ms < r_period) begin
                            r_tgt <= r_period;
                        end else begin
                            r_tgt <= elapsed_ms;
                        end
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_den   <= DEN_W'(ppu_eff) * DEN_W'(r_tgt);
                    r_zero  <= (r_tgt == '0);
                    r_state <= S_WSTART;
                end
                S_WSTART: begin
                    r_state <= S_WWAIT;
                end
                S_WWAIT: begin
                    if (div_sts.done) begin
                        r_power <= r_zero ? '0 : div_quo[CNT_W-1:0];
                        r_state <= (r_op == OP_SAMPLE) ? S_SAMPLE : S_TSTART;
                    end
                end
                S_SAMPLE: begin
                    // Replace the oldest sample and keep the sum in step with it.
                    r_window[r_slot] <= r_power;
                    r_sum <= r_sum - SUM_W'(r_window[r_slot]) + SUM_W'(r_power);
                    r_slot <= (r_slot == SLOT_W'(AVG_DEPTH - 1)) ? '0
                                                                 : r_slot + SLOT_W'(1);
                    if (r_fill < FILL_W'(AVG_DEPTH)) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    r_state <= S_TSTART;
                end
                S_TSTART: begin
                    r_state <= S_TWAIT;
                end
                S_TWAIT: begin
                    if (div_sts.done) begin
                        // The total saturates when the quotient exceeds 32 bits.
                        r_total <= (div_quo[NUM_W-1:CNT_W] != '0) ? '1
                                                                  : div_quo[CNT_W-1:0];
                        r_state <= S_ASTART;
                    end
                end
                S_ASTART: begin
                    r_state <= S_AWAIT;
                end
                S_AWAIT: begin
                    if (div_sts.done) begin
                        r_avg   <= (r_fill == '0) ? '0 : div_quo[CNT_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_acc;
                        r_out_data  <= {r_avg, r_total, r_power, r_period, r_count};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.start |-> !div_sts.busy)
        else $error("divider started while still busy");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |=> (r_count == $past(r_count) + CNT_W'(r_acc)))
        else $error("pulse count moved without a counted pulse");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(AVG_DEPTH))
        else $error("average fill count beyond window depth");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the final state");
`endif

endmodule
